@@ hdl/emirp_number_test_unit_defines.svh @@
// ----------------------------------------------------------------------------
// Emirp test unit assertion macros
// Shared assertion forms for the emirp test unit.
// ----------------------------------------------------------------------------
`ifndef EMIRP_NUMBER_TEST_UNIT_DEFINES_SVH
`define EMIRP_NUMBER_TEST_UNIT_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define EMIRP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define EMIRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/emirp_pkg.sv @@
// ----------------------------------------------------------------------------
// Emirp test package
// Widths, microcode encodings and the control program of the emirp test unit.
// ----------------------------------------------------------------------------
package emirp_pkg;

  localparam int INPUT_BITS = 31;
  localparam int NUM_W      = INPUT_BITS;
  localparam int REV_W      = 34;
  localparam int D_W        = REV_W / 2 + 1;
  localparam int SQ_W       = 2 * D_W;
  localparam int CNT_W      = $clog2(REV_W + 1);
  localparam int RADIX      = 10;
  localparam int FIRST_DIV  = 2;
  localparam int IN_TDATA_W  = ((NUM_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((REV_W + 3 + 7) / 8) * 8;
  localparam int STEP_W     = 4;

  // The quotient by ten is (v * RECIP10) >> RECIP10_SH, exact for values up to 32 bits.
  localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
  localparam int          RECIP10_SH = 35;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_RDIV,
    OP_RACC,
    OP_PINIT,
    OP_PDIV,
    OP_PFAIL,
    OP_PNEXT,
    OP_PEND,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_IN,
    C_DIV,
    C_VZERO,
    C_OPLT2,
    C_SQGT,
    C_REMZ,
    C_FIRST,
    C_OUT
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    logic  hold;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic v_zero;
    logic op_lt2;
    logic sq_gt;
    logic rem_zero;
    logic first;
  } dp_stat_t;

  typedef struct packed {
    logic     in_fire;
    logic     div_done;
    logic     out_free;
    dp_stat_t dp;
  } stat_t;

  typedef struct packed {
    logic             is_emirp;
    logic             number_is_prime;
    logic             reversed_is_prime;
    logic [REV_W-1:0] reversed_value;
  } res_t;

  localparam step_t S_IDLE  = 4'd0;
  localparam step_t S_RTEST = 4'd1;
  localparam step_t S_RDIV  = 4'd2;
  localparam step_t S_RACC  = 4'd3;
  localparam step_t S_PINIT = 4'd4;
  localparam step_t S_PTEST = 4'd5;
  localparam step_t S_PDIV  = 4'd6;
  localparam step_t S_PWAIT = 4'd7;
  localparam step_t S_PCHK  = 4'd8;
  localparam step_t S_PNEXT = 4'd9;
  localparam step_t S_PEND  = 4'd10;
  localparam step_t S_EMIT  = 4'd11;

  function automatic uword_t ucode(input step_t step);
    uword_t w;
    case (step)
      S_IDLE:  w = '{op: OP_LOAD,  cond: C_IN,     hold: 1'b1, target: S_RTEST};
      S_RTEST: w = '{op: OP_NOP,   cond: C_VZERO,  hold: 1'b0, target: S_PINIT};
      S_RDIV:  w = '{op: OP_RDIV,  cond: C_NONE,   hold: 1'b0, target: S_IDLE};
      S_RACC:  w = '{op: OP_RACC,  cond: C_ALWAYS, hold: 1'b0, target: S_RTEST};
      S_PINIT: w = '{op: OP_PINIT, cond: C_OPLT2,  hold: 1'b0, target: S_PEND};
      S_PTEST: w = '{op: OP_NOP,   cond: C_SQGT,   hold: 1'b0, target: S_PEND};
      S_PDIV:  w = '{op: OP_PDIV,  cond: C_NONE,   hold: 1'b0, target: S_IDLE};
      S_PWAIT: w = '{op: OP_NOP,   cond: C_DIV,    hold: 1'b1, target: S_PCHK};
      S_PCHK:  w = '{op: OP_PFAIL, cond: C_REMZ,   hold: 1'b0, target: S_PEND};
      S_PNEXT: w = '{op: OP_PNEXT, cond: C_ALWAYS, hold: 1'b0, target: S_PTEST};
      S_PEND:  w = '{op: OP_PEND,  cond: C_FIRST,  hold: 1'b0, target: S_PINIT};
      S_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT,    hold: 1'b1, target: S_IDLE};
      default: w = '{op: OP_NOP,   cond: C_ALWAYS, hold: 1'b0, target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

@@ hdl/emirp_div.sv @@
// ----------------------------------------------------------------------------
// Emirp iterative divider
// Restoring divider, one quotient bit per cycle, shared by all trial divisions.
// ----------------------------------------------------------------------------
module emirp_div
  import emirp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [REV_W-1:0] dividend,
  input  logic [REV_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [REV_W-1:0] rem
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [REV_W-1:0] quo_r;
  logic [REV_W-1:0] rem_r;
  logic [REV_W-1:0] dvs_r;
  logic [REV_W:0]   trial;
  logic [REV_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem_r, quo_r[REV_W-1]};
    ge    = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(REV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[REV_W-1:0] : trial[REV_W-1:0];
      quo_r <= {quo_r[REV_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ hdl/emirp_seq.sv @@
// ----------------------------------------------------------------------------
// Emirp microcode sequencer
// Step counter over the control program with conditional jumps and waits.
// ----------------------------------------------------------------------------
module emirp_seq
  import emirp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output op_t   op
);

  step_t  pc_r;
  step_t  pc_nxt;
  uword_t word;
  logic   taken;

  always_comb begin
    word = ucode(pc_r);
    case (word.cond)
      C_NONE:   taken = 1'b0;
      C_ALWAYS: taken = 1'b1;
      C_IN:     taken = stat.in_fire;
      C_DIV:    taken = stat.div_done;
      C_VZERO:  taken = stat.dp.v_zero;
      C_OPLT2:  taken = stat.dp.op_lt2;
      C_SQGT:   taken = stat.dp.sq_gt;
      C_REMZ:   taken = stat.dp.rem_zero;
      C_FIRST:  taken = stat.dp.first;
      C_OUT:    taken = stat.out_free;
      default:  taken = 1'b0;
    endcase
    if (taken) begin
      pc_nxt = word.target;
    end else if (word.hold) begin
      pc_nxt = pc_r;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign op = word.op;

endmodule

@@ hdl/emirp_dp.sv @@
// ----------------------------------------------------------------------------
// Emirp datapath
// Digit reversal and trial division registers, driven by the control word.
// ----------------------------------------------------------------------------
module emirp_dp
  import emirp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  op_t              op,
  input  logic             in_fire,
  input  logic [NUM_W-1:0] number,
  input  logic [REV_W-1:0] div_rem,
  output logic             div_start,
  output logic [REV_W-1:0] div_dividend,
  output logic [REV_W-1:0] div_divisor,
  output dp_stat_t         stat,
  output res_t             res
);

  logic [NUM_W-1:0] num_r;
  logic [NUM_W-1:0] v_r;
  logic [NUM_W-1:0] q_r;
  logic [REV_W-1:0] rev_r;
  logic [REV_W-1:0] x_r;
  logic [D_W-1:0]   d_r;
  logic [SQ_W-1:0]  sq_r;
  logic             flag_r;
  logic             which_r;
  logic             pnum_r;
  logic             prev_r;
  logic [REV_W-1:0] opnd;
  logic [NUM_W+31:0] prod;
  logic [3:0]       q10_lo;
  logic [3:0]       digit;

  assign opnd = which_r ? rev_r : REV_W'(num_r);

  always_comb begin
    div_start    = op == OP_PDIV;
    div_dividend = x_r;
    div_divisor  = REV_W'(d_r);
  end

  always_comb begin
    prod   = (NUM_W+32)'(v_r) * (NUM_W+32)'(RECIP10);
    q10_lo = {q_r[0], 3'b000} + {q_r[2:0], 1'b0};
    digit  = v_r[3:0] - q10_lo;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      which_r <= 1'b0;
    end else if (op == OP_LOAD && in_fire) begin
      which_r <= 1'b0;
    end else if (op == OP_PEND) begin
      which_r <= ~which_r;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        if (in_fire) begin
          num_r <= number;
          v_r   <= number;
          rev_r <= '0;
        end
      end
      OP_RDIV: begin
        q_r <= NUM_W'(prod >> RECIP10_SH);
      end
      OP_RACC: begin
        rev_r <= (rev_r << 3) + (rev_r << 1) + REV_W'(digit);
        v_r   <= q_r;
      end
      OP_PINIT: begin
        x_r    <= opnd;
        d_r    <= D_W'(FIRST_DIV);
        sq_r   <= SQ_W'(FIRST_DIV * FIRST_DIV);
        flag_r <= opnd >= REV_W'(FIRST_DIV);
      end
      OP_PFAIL: begin
        if (div_rem == '0) begin
          flag_r <= 1'b0;
        end
      end
      OP_PNEXT: begin
        d_r  <= d_r + 1'b1;
        sq_r <= sq_r + SQ_W'({d_r, 1'b1});
      end
      OP_PEND: begin
        if (which_r) begin
          prev_r <= flag_r;
        end else begin
          pnum_r <= flag_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.v_zero   = v_r == '0;
    stat.op_lt2   = opnd < REV_W'(FIRST_DIV);
    stat.sq_gt    = sq_r > SQ_W'(x_r);
    stat.rem_zero = div_rem == '0;
    stat.first    = !which_r;
  end

  always_comb begin
    res.number_is_prime   = pnum_r;
    res.reversed_is_prime = prev_r;
    res.reversed_value    = rev_r;
    res.is_emirp          = pnum_r && prev_r && (rev_r != REV_W'(num_r));
  end

endmodule

@@ hdl/emirp_number_test_unit.sv @@
// ----------------------------------------------------------------------------
// Emirp number test unit
// Reverses the decimal digits of a number and tests both values for
// primality by trial division.
// ----------------------------------------------------------------------------
// The input channel takes one word holding the number to test, and the
// output channel gives one word per input with the three prime flags and the
// digit reversal. A short control program steps a datapath that first takes
// the number apart digit by digit, then tries divisors d upward from two while
// d*d is not above the value and none has divided it, first for the number and
// then for its reversal. Digits are split off by a multiply with the reciprocal
// of ten, and every trial division runs in a shared one-bit-per-cycle divider,
// so each digit takes a test, a divide and an accumulate step, and each trial
// divisor a square test, a divider run, a remainder check and a step on.
// One item is worked on at a time; the next word is taken once the result
// has been placed in the output register. A stalled receiver holds the
// result there, and the result of the following item waits at the last
// step until the register is free. Reset returns the control program to its
// first step and drops the output valid; no clearing pass.
// ----------------------------------------------------------------------------
`include "emirp_number_test_unit_defines.svh"

module emirp_number_test_unit
  import emirp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // number
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // is_emirp, number_is_prime,
                                             // reversed_is_prime, reversed_value
);

  op_t              op;
  stat_t            stat;
  dp_stat_t         dp_stat;
  res_t             res;
  res_t             out_res_r;
  logic             out_valid_r;
  logic             in_fire;
  logic             out_free;
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [REV_W-1:0] div_dividend;
  logic [REV_W-1:0] div_divisor;
  logic [REV_W-1:0] div_rem;

  assign in_tready = op == OP_LOAD;
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    stat.in_fire  = in_fire;
    stat.div_done = div_done;
    stat.out_free = out_free;
    stat.dp       = dp_stat;
  end

  emirp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .op    (op)
  );

  emirp_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .in_fire      (in_fire),
    .number       (in_tdata[NUM_W-1:0]),
    .div_rem      (div_rem),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .stat         (dp_stat),
    .res          (res)
  );

  emirp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == OP_EMIT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == OP_EMIT && out_free) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_res_r.reversed_value, out_res_r.reversed_is_prime,
                                    out_res_r.number_is_prime, out_res_r.is_emirp});

  `EMIRP_ASSERT_NOW(a_div_start_idle, clk, rst_n, div_start, !div_busy, "divider restarted while busy")
  `EMIRP_ASSERT_NOW(a_div_nonzero, clk, rst_n, div_start, div_divisor != '0, "division by zero")
  `EMIRP_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_fire, !in_tready, "input taken twice")
  `EMIRP_ASSERT_NEXT(a_emit_valid, clk, rst_n, op == OP_EMIT && out_free, out_tvalid, "result lost")

endmodule
